### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the shape pair collision test.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion on an explicit clock and active-low reset
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assertion on the house clock and reset names
`define ASSERT_STD(lbl, prop, msg) `ASSERT_AT(lbl, clk_i, rst_ni, prop, msg)

`endif

### rtl/spc_pkg.sv
// ----------------------------------------------------------------------------
// spc_pkg
// Types and constants for the shape pair collision test.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package spc_pkg;

  localparam int CoordW = 16;            // Q12.4 coordinate and size width
  localparam int AbsW   = CoordW;        // |x_a - x_b| never exceeds 16 bits
  localparam int ExtW   = CoordW + 1;    // sum of two extents
  localparam int GapW   = CoordW + 1;    // clearance in the doubled frame
  localparam int RadW   = CoordW + 1;    // sum of two radii
  localparam int SqW    = 2 * GapW;      // squared clearance / radius sum

  typedef enum logic [1:0] {
    KIND_RECT   = 2'd0,
    KIND_CIRCLE = 2'd1,
    KIND_POINT  = 2'd2
  } kind_e;

  // which test decides the pair
  typedef enum logic [1:0] {
    CLS_NONE = 2'd0,   // never hits
    CLS_BOX  = 2'd1,   // inclusive box containment / overlap
    CLS_CIRC = 2'd2    // strict squared distance test
  } cls_e;

  typedef struct packed {
    logic [1:0]               kind;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic [CoordW-1:0]        width;
    logic [CoordW-1:0]        height;
    logic [CoordW-1:0]        radius;
  } shape_t;

  // gap stage to distance stage
  typedef struct packed {
    cls_e            cls;
    logic [GapW-1:0] gx;
    logic [GapW-1:0] gy;
    logic [RadW-1:0] rsum;
  } gap_t;

endpackage

`default_nettype wire

### rtl/spc_if.sv
// ----------------------------------------------------------------------------
// spc_in_if / spc_out_if
// Valid/ready channels carrying a shape pair and its collision result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface spc_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         shape_a;
  logic signed [15:0] x_a;
  logic signed [15:0] y_a;
  logic [15:0]        width_a;
  logic [15:0]        height_a;
  logic [15:0]        radius_a;
  logic [1:0]         shape_b;
  logic signed [15:0] x_b;
  logic signed [15:0] y_b;
  logic [15:0]        width_b;
  logic [15:0]        height_b;
  logic [15:0]        radius_b;

  modport source (
    output valid, shape_a, x_a, y_a, width_a, height_a, radius_a,
    output shape_b, x_b, y_b, width_b, height_b, radius_b,
    input  ready
  );
  modport sink (
    input  valid, shape_a, x_a, y_a, width_a, height_a, radius_a,
    input  shape_b, x_b, y_b, width_b, height_b, radius_b,
    output ready
  );
endinterface

interface spc_out_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink   (input valid, hit, output ready);
endinterface

`default_nettype wire

### rtl/shape_pair_collision_test.sv
// ----------------------------------------------------------------------------
// shape_pair_collision_test
// Pipelined rectangle / circle / point pair collision test.
// ----------------------------------------------------------------------------
// Accepts one shape pair per clock while the output side is not stalled and
// returns one hit bit per pair, in order. The four register stages (class and
// deltas, per-axis clearance, squaring multipliers, compare) all advance on one
// shared enable; the last stage doubles as the output register. The input is
// held off exactly while a finished result waits for the consumer, and then
// every stage holds, bubbles included.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module shape_pair_collision_test (
  input  logic     clk_i,
  input  logic     rst_ni,
  spc_in_if.sink   in_i,
  spc_out_if.source out_o
);
  import spc_pkg::*;

  shape_t shp_a, shp_b;
  gap_t   gap;
  logic   gap_vld;
  logic   res_vld;
  logic   res_hit;
  logic   adv;

  // Whole pipe moves unless a finished result is held by the consumer.
  assign adv = !res_vld || out_o.ready;

  always_comb begin
    shp_a.kind   = in_i.shape_a;
    shp_a.x      = in_i.x_a;
    shp_a.y      = in_i.y_a;
    shp_a.width  = in_i.width_a;
    shp_a.height = in_i.height_a;
    shp_a.radius = in_i.radius_a;
    shp_b.kind   = in_i.shape_b;
    shp_b.x      = in_i.x_b;
    shp_b.y      = in_i.y_b;
    shp_b.width  = in_i.width_b;
    shp_b.height = in_i.height_b;
    shp_b.radius = in_i.radius_b;
  end

  // Stages 1-2: which test applies, and how far apart the shapes are per axis
  // after the rectangle extents are taken off (doubled Q12.4 frame).
  spc_gap u_gap (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (in_i.valid),
    .shp_a_i(shp_a),
    .shp_b_i(shp_b),
    .vld_o  (gap_vld),
    .gap_o  (gap)
  );

  // Stages 3-4: squared clearance against squared radius sum, or the
  // inclusive box test for rectangle and point pairs.
  spc_dist u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (gap_vld),
    .gap_i  (gap),
    .vld_o  (res_vld),
    .hit_o  (res_hit)
  );

  assign in_i.ready  = adv;
  assign out_o.valid = res_vld;
  assign out_o.hit   = res_hit;

  // back-pressure only when a result is actually blocked
  `ASSERT_STD(a_ready_cause, !in_i.ready |-> (out_o.valid && !out_o.ready), "spurious stall")
  // a stall freezes the middle of the pipe
  `ASSERT_STD(a_stall_hold, !in_i.ready |=> $stable(gap_vld), "mid stage moved in stall")
  // a waiting result stays put until taken
  `ASSERT_STD(a_out_hold, (out_o.valid && !out_o.ready) |=> (out_o.valid && $stable(out_o.hit)), "output changed while held")

endmodule

`default_nettype wire

### rtl/spc_gap.sv
// ----------------------------------------------------------------------------
// spc_gap
// Stages 1-2: pair class, center deltas, extents, then per-axis clearance.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spc_gap (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            vld_i,
  input  spc_pkg::shape_t shp_a_i,
  input  spc_pkg::shape_t shp_b_i,
  output logic            vld_o,
  output spc_pkg::gap_t   gap_o
);
  import spc_pkg::*;

  // stage 1
  cls_e                   cls_d, cls_q;
  logic [AbsW-1:0]        adx_d, adx_q, ady_d, ady_q;
  logic [ExtW-1:0]        ex_d, ex_q, ey_d, ey_q;
  logic [RadW-1:0]        rs_d, rs_q;
  logic                   v1_q;
  logic signed [AbsW:0]   dx, dy;
  logic [AbsW:0]          dx_abs, dy_abs;
  logic                   a_rect, b_rect, a_circ, b_circ, a_pt, b_pt;

  // stage 2
  gap_t                   gap_d, gap_q;
  logic                   v2_q;
  logic [GapW-1:0]        dx2, dy2;

  always_comb begin
    a_rect = (shp_a_i.kind == KIND_RECT);
    b_rect = (shp_b_i.kind == KIND_RECT);
    a_circ = (shp_a_i.kind == KIND_CIRCLE);
    b_circ = (shp_b_i.kind == KIND_CIRCLE);
    a_pt   = (shp_a_i.kind == KIND_POINT);
    b_pt   = (shp_b_i.kind == KIND_POINT);

    // unused kind code or point/point: never a hit
    if (!(a_rect || a_circ || a_pt) || !(b_rect || b_circ || b_pt) || (a_pt && b_pt)) begin
      cls_d = CLS_NONE;
    end else if (a_circ || b_circ) begin
      cls_d = CLS_CIRC;
    end else begin
      cls_d = CLS_BOX;
    end

    dx     = {shp_a_i.x[CoordW-1], shp_a_i.x} - {shp_b_i.x[CoordW-1], shp_b_i.x};
    dy     = {shp_a_i.y[CoordW-1], shp_a_i.y} - {shp_b_i.y[CoordW-1], shp_b_i.y};
    dx_abs = dx[AbsW] ? (AbsW+1)'(-dx) : dx;
    dy_abs = dy[AbsW] ? (AbsW+1)'(-dy) : dy;
    adx_d  = dx_abs[AbsW-1:0];
    ady_d  = dy_abs[AbsW-1:0];

    // half extents in the doubled frame equal the full sizes
    ex_d = (a_rect ? ExtW'(shp_a_i.width)  : '0) + (b_rect ? ExtW'(shp_b_i.width)  : '0);
    ey_d = (a_rect ? ExtW'(shp_a_i.height) : '0) + (b_rect ? ExtW'(shp_b_i.height) : '0);
    rs_d = (a_circ ? RadW'(shp_a_i.radius) : '0) + (b_circ ? RadW'(shp_b_i.radius) : '0);
  end

  // clearance beyond the box edge, zero when inside
  always_comb begin
    dx2       = {adx_q, 1'b0};
    dy2       = {ady_q, 1'b0};
    gap_d.cls  = cls_q;
    gap_d.gx   = (dx2 > ex_q) ? GapW'(dx2 - ex_q) : '0;
    gap_d.gy   = (dy2 > ey_q) ? GapW'(dy2 - ey_q) : '0;
    gap_d.rsum = rs_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= vld_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cls_q <= cls_d;
      adx_q <= adx_d;
      ady_q <= ady_d;
      ex_q  <= ex_d;
      ey_q  <= ey_d;
      rs_q  <= rs_d;
      gap_q <= gap_d;
    end
  end

  assign vld_o = v2_q;
  assign gap_o = gap_q;

endmodule

`default_nettype wire

### rtl/spc_dist.sv
// ----------------------------------------------------------------------------
// spc_dist
// Stages 3-4: squares of clearance and radius sum, then the final decision.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module spc_dist (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  spc_pkg::gap_t gap_i,
  output logic          vld_o,
  output logic          hit_o
);
  import spc_pkg::*;

  // stage 3
  logic [SqW-1:0]  sqx_q, sqy_q, sqr_q;
  cls_e            cls3_q;
  logic            box3_q;
  logic            v3_q;

  // stage 4
  logic [SqW:0]    dsum;
  logic [SqW+1:0]  rlim;
  logic            hit_d, hit_q;
  logic            v4_q;

  always_comb begin
    dsum = (SqW+1)'(sqx_q) + (SqW+1)'(sqy_q);
    rlim = {sqr_q, 2'b00};   // (2r)^2 = 4 r^2
    case (cls3_q)
      CLS_CIRC: hit_d = ((SqW+2)'(dsum) < rlim);
      CLS_BOX:  hit_d = box3_q;
      default:  hit_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= vld_i;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sqx_q  <= SqW'(gap_i.gx) * SqW'(gap_i.gx);
      sqy_q  <= SqW'(gap_i.gy) * SqW'(gap_i.gy);
      sqr_q  <= SqW'(gap_i.rsum) * SqW'(gap_i.rsum);
      cls3_q <= gap_i.cls;
      box3_q <= (gap_i.gx == '0) && (gap_i.gy == '0);
      hit_q  <= hit_d;
    end
  end

  assign vld_o = v4_q;
  assign hit_o = hit_q;

  `ASSERT_STD(a_none_no_hit, (en_i && v3_q && cls3_q == CLS_NONE) |=> !hit_o, "none-class hit")
  `ASSERT_STD(a_box_outside, (en_i && v3_q && cls3_q == CLS_BOX && !box3_q) |=> !hit_o, "box miss hit")
  `ASSERT_STD(a_hold_result, (vld_o && !en_i) |=> (vld_o && $stable(hit_o)), "result moved in stall")

endmodule

`default_nettype wire

### tb/spc_hit_checker.sv
// ----------------------------------------------------------------------------
// spc_hit_checker
// Watches both channels of the shape pair collision test. It works out the
// hit bit of every accepted shape pair and matches each returned hit, in
// order, against the oldest hit still owed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spc_hit_checker (
  input  logic clk_i,
  input  logic rst_ni,
  spc_in_if    in_mon,
  spc_out_if   out_mon,
  output int   fail_count_o,
  output int   pending_o,
  output int   hits_o
);
  import spc_pkg::*;

  bit owed_hits[$];
  int fails;
  int reported;
  int hits;

  function automatic longint clamp_to(longint v, longint lo, longint hi);
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v;
  endfunction

  // strict: squared distance below squared radius
  function automatic bit closer_than(longint dx, longint dy, longint r);
    return dx * dx + dy * dy < r * r;
  endfunction

  // Doubled frame: centers times two, half extent equals full size,
  // radius times two. Everything stays exact in 64 bits.
  function automatic bit pair_hits(shape_t a, shape_t b);
    longint ax, ay, bx, by;
    longint ahw, ahh, bhw, bhh;
    longint ar, br;
    ax  = 2 * longint'($signed(a.x));
    ay  = 2 * longint'($signed(a.y));
    bx  = 2 * longint'($signed(b.x));
    by  = 2 * longint'($signed(b.y));
    ahw = longint'(a.width);
    ahh = longint'(a.height);
    bhw = longint'(b.width);
    bhh = longint'(b.height);
    ar  = 2 * longint'(a.radius);
    br  = 2 * longint'(b.radius);
    if (a.kind == KIND_CIRCLE && b.kind == KIND_CIRCLE)
      return closer_than(ax - bx, ay - by, ar + br);
    if (a.kind == KIND_RECT && b.kind == KIND_RECT)
      return !(ax + ahw < bx - bhw || ax - ahw > bx + bhw ||
               ay + ahh < by - bhh || ay - ahh > by + bhh);
    if (a.kind == KIND_CIRCLE && b.kind == KIND_RECT)
      return closer_than(ax - clamp_to(ax, bx - bhw, bx + bhw),
                         ay - clamp_to(ay, by - bhh, by + bhh), ar);
    if (a.kind == KIND_RECT && b.kind == KIND_CIRCLE)
      return closer_than(bx - clamp_to(bx, ax - ahw, ax + ahw),
                         by - clamp_to(by, ay - ahh, ay + ahh), br);
    if (a.kind == KIND_POINT && b.kind == KIND_CIRCLE)
      return closer_than(ax - bx, ay - by, br);
    if (a.kind == KIND_CIRCLE && b.kind == KIND_POINT)
      return closer_than(bx - ax, by - ay, ar);
    if (a.kind == KIND_POINT && b.kind == KIND_RECT)
      return ax >= bx - bhw && ax <= bx + bhw && ay >= by - bhh && ay <= by + bhh;
    if (a.kind == KIND_RECT && b.kind == KIND_POINT)
      return bx >= ax - ahw && bx <= ax + ahw && by >= ay - ahh && by <= ay + ahh;
    return 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    shape_t sa, sb;
    bit     want;
    if (!rst_ni) begin
      owed_hits.delete();
      fails    = 0;
      reported = 0;
      hits     = 0;
    end else begin
      // result side first; a pair never leaves in the cycle it enters
      if (out_mon.valid && out_mon.ready) begin
        if (out_mon.hit === 1'b1) hits++;
        if (owed_hits.size() == 0) begin
          fails++;
          if (reported < 10) begin
            reported++;
            $display("%0t: unexpected result hit=%b, nothing owed", $realtime, out_mon.hit);
          end
        end else begin
          want = owed_hits.pop_front();
          if (out_mon.hit !== want) begin
            fails++;
            if (reported < 10) begin
              reported++;
              $display("%0t: hit mismatch: expected %b, got %b",
                       $realtime, want, out_mon.hit);
            end
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        sa = '{kind: in_mon.shape_a, x: in_mon.x_a, y: in_mon.y_a,
               width: in_mon.width_a, height: in_mon.height_a, radius: in_mon.radius_a};
        sb = '{kind: in_mon.shape_b, x: in_mon.x_b, y: in_mon.y_b,
               width: in_mon.width_b, height: in_mon.height_b, radius: in_mon.radius_b};
        owed_hits.insert(owed_hits.size(), pair_hits(sa, sb));
      end
    end
    fail_count_o <= fails;
    pending_o    <= owed_hits.size();
    hits_o       <= hits;
  end

endmodule

### tb/shape_pair_collision_test_tb.sv
// ----------------------------------------------------------------------------
// shape_pair_collision_test_tb
// Drives shape pairs into the collision test: a directed set of edge and
// contact cases, then random pairs that are mostly placed near or exactly at
// contact distance. The sender runs in bursts, the receiver stalls on its own
// pattern; spc_hit_checker predicts and compares, this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module shape_pair_collision_test_tb;
  import spc_pkg::*;

  // kind code that matches no pairing
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam int NumRandom = 1650;
  localparam int DrainAt   = 825;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic rx_ready = 1'b0;
  logic [15:0] rx_cyc = '0;

  int fail_count;
  int pending;
  int hit_count;

  int n_directed, n_wide, n_near, n_contact;
  int burst_left;

  spc_in_if  in_if ();
  spc_out_if out_if ();

  assign out_if.ready = rx_ready;

  shape_pair_collision_test uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  spc_hit_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_if),
    .out_mon      (out_if),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .hits_o       (hit_count)
  );

  always #10 clk_i = ~clk_i;

  // Receiver: four stall patterns, taken in turn as rx_cyc[10:9] steps.
  always @(posedge clk_i) begin
    rx_cyc <= rx_cyc + 16'd1;
    case (rx_cyc[10:9])
      2'd0: rx_ready <= 1'b1;                          // never stalls
      2'd1: rx_ready <= ($urandom_range(0, 3) != 0);   // light stalls
      2'd2: rx_ready <= ($urandom_range(0, 3) == 0);   // heavy stalls
      default: rx_ready <= ((rx_cyc % 11) > 3);        // periodic stall
    endcase
  end

  function automatic shape_t mk(logic [1:0] k, int x, int y, int w, int h, int r);
    return '{kind: k, x: 16'(x), y: 16'(y), width: 16'(w), height: 16'(h),
             radius: 16'(r)};
  endfunction

  // mostly legal kinds, now and then the unused code
  function automatic logic [1:0] pick_kind(bit allow_unused);
    if (allow_unused && $urandom_range(0, 19) == 0) return KIND_UNUSED;
    return 2'($urandom_range(0, 2));
  endfunction

  // how far a shape reaches from its center along one axis, in Q12.4
  function automatic int reach(shape_t s, bit on_y);
    if (s.kind == KIND_RECT) return int'(on_y ? s.height : s.width) >> 1;
    if (s.kind == KIND_CIRCLE) return int'(s.radius);
    return 0;
  endfunction

  task automatic put_fields(input shape_t a, input shape_t b);
    in_if.shape_a  <= a.kind;
    in_if.x_a      <= a.x;
    in_if.y_a      <= a.y;
    in_if.width_a  <= a.width;
    in_if.height_a <= a.height;
    in_if.radius_a <= a.radius;
    in_if.shape_b  <= b.kind;
    in_if.x_b      <= b.x;
    in_if.y_b      <= b.y;
    in_if.width_b  <= b.width;
    in_if.height_b <= b.height;
    in_if.radius_b <= b.radius;
  endtask

  // Present one pair and hold it until the block takes it. Bursts end in a
  // short gap with junk on the payload; some bursts are long with no gaps.
  task automatic drive_pair(input shape_t a, input shape_t b);
    in_if.valid <= 1'b1;
    put_fields(a, b);
    do @(posedge clk_i); while (!in_if.ready);
    burst_left--;
    if (burst_left <= 0) begin
      in_if.valid <= 1'b0;
      put_fields(shape_t'({$urandom, $urandom, $urandom}),
                 shape_t'({$urandom, $urandom, $urandom}));
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 24);
    end
  endtask

  // hold off the sender until every owed hit has come back
  task automatic drain;
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    shape_t a, b;
    int     cap, off, sep, mode;
    bit     on_y;

    in_if.valid = 1'b0;
    put_fields(shape_t'('0), shape_t'('0));
    n_directed = 0;
    n_wide     = 0;
    n_near     = 0;
    n_contact  = 0;
    burst_left = 10;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed: Q12.4, so 16 is one unit ----
    // rectangles whose edges just touch hit (inclusive); one step apart miss
    drive_pair(mk(KIND_RECT, 0, 0, 32, 32, 0), mk(KIND_RECT, 32, 0, 32, 32, 0));
    drive_pair(mk(KIND_RECT, 0, 0, 32, 32, 0), mk(KIND_RECT, 33, 0, 32, 32, 0));
    drive_pair(mk(KIND_RECT, 0, 0, 32, 32, 0), mk(KIND_RECT, 5, -32, 32, 32, 0));
    // circles at exactly the radius sum miss (strict); one step closer hit
    drive_pair(mk(KIND_CIRCLE, 0, 0, 0, 0, 16), mk(KIND_CIRCLE, 32, 0, 0, 0, 16));
    drive_pair(mk(KIND_CIRCLE, 0, 0, 0, 0, 16), mk(KIND_CIRCLE, 0, 31, 0, 0, 16));
    // circle against rectangle side, at contact and one step closer
    drive_pair(mk(KIND_CIRCLE, 32, 0, 0, 0, 16), mk(KIND_RECT, 0, 0, 32, 32, 0));
    drive_pair(mk(KIND_CIRCLE, 31, 0, 0, 0, 16), mk(KIND_RECT, 0, 0, 32, 32, 0));
    // near a corner: doubled distance 10, so radius 5 misses and 6 hits
    drive_pair(mk(KIND_RECT, 0, 0, 32, 32, 0), mk(KIND_CIRCLE, 19, 20, 0, 0, 5));
    drive_pair(mk(KIND_RECT, 0, 0, 32, 32, 0), mk(KIND_CIRCLE, 19, 20, 0, 0, 6));
    // point on the circle misses, just inside hits
    drive_pair(mk(KIND_POINT, 16, 0, 0, 0, 0), mk(KIND_CIRCLE, 0, 0, 0, 0, 16));
    drive_pair(mk(KIND_POINT, 15, 0, 0, 0, 0), mk(KIND_CIRCLE, 0, 0, 0, 0, 16));
    drive_pair(mk(KIND_CIRCLE, 0, 0, 0, 0, 16), mk(KIND_POINT, 0, -15, 0, 0, 0));
    // point on a rectangle corner hits, just outside misses
    drive_pair(mk(KIND_POINT, 16, 16, 0, 0, 0), mk(KIND_RECT, 0, 0, 32, 32, 0));
    drive_pair(mk(KIND_POINT, 17, 16, 0, 0, 0), mk(KIND_RECT, 0, 0, 32, 32, 0));
    drive_pair(mk(KIND_RECT, 0, 0, 32, 32, 0), mk(KIND_POINT, -16, -16, 0, 0, 0));
    // two points never collide, even at the same spot
    drive_pair(mk(KIND_POINT, 7, 7, 0, 0, 0), mk(KIND_POINT, 7, 7, 0, 0, 0));
    // zero radius never hits; zero-size rectangles act as points, inclusive
    drive_pair(mk(KIND_CIRCLE, 0, 0, 0, 0, 0), mk(KIND_CIRCLE, 0, 0, 0, 0, 0));
    drive_pair(mk(KIND_CIRCLE, 0, 0, 0, 0, 0), mk(KIND_RECT, 0, 0, 64, 64, 0));
    drive_pair(mk(KIND_RECT, 3, 3, 0, 0, 0), mk(KIND_RECT, 3, 3, 0, 0, 0));
    drive_pair(mk(KIND_RECT, 3, 3, 0, 0, 0), mk(KIND_POINT, 3, 3, 0, 0, 0));
    // unused kind code on either side never hits
    drive_pair(mk(KIND_UNUSED, 0, 0, 32, 32, 32), mk(KIND_RECT, 0, 0, 32, 32, 0));
    drive_pair(mk(KIND_CIRCLE, 0, 0, 0, 0, 32), mk(KIND_UNUSED, 0, 0, 32, 32, 32));
    // sizes of the wrong kind are ignored
    drive_pair(mk(KIND_POINT, 1000, 0, 65535, 65535, 65535),
               mk(KIND_CIRCLE, 0, 0, 65535, 65535, 16));
    drive_pair(mk(KIND_CIRCLE, 2000, 0, 65535, 65535, 16),
               mk(KIND_RECT, 0, 0, 32, 32, 65535));
    // extremes of coordinates and sizes
    drive_pair(mk(KIND_CIRCLE, -32768, -32768, 0, 0, 65535),
               mk(KIND_CIRCLE, 32767, 32767, 0, 0, 65535));
    drive_pair(mk(KIND_RECT, -32768, -32768, 65535, 65535, 0),
               mk(KIND_RECT, 32767, 32767, 65535, 65535, 0));
    n_directed = 26;
    drain();

    // ---- random ----
    for (int n = 0; n < NumRandom; n++) begin
      if (n == DrainAt) drain();
      mode = $urandom_range(0, 9);
      if (mode < 2) begin
        // anything at all: every bit of every field
        a = shape_t'({$urandom, $urandom, $urandom});
        b = shape_t'({$urandom, $urandom, $urandom});
        a.kind = pick_kind(1'b1);
        b.kind = pick_kind(1'b1);
        n_wide++;
      end else if (mode < 6) begin
        // second shape placed near the first, mostly small sizes
        cap = ($urandom_range(0, 9) == 0) ? 65535 : $urandom_range(0, 2047);
        a = mk(pick_kind(1'b1), $urandom, $urandom, $urandom_range(0, cap),
               $urandom_range(0, cap), $urandom_range(0, cap));
        b = mk(pick_kind(1'b1), 0, 0, $urandom_range(0, cap),
               $urandom_range(0, cap), $urandom_range(0, cap));
        b.x = a.x + 16'(int'($urandom_range(0, 4 * cap + 8)) - (2 * cap + 4));
        b.y = a.y + 16'(int'($urandom_range(0, 4 * cap + 8)) - (2 * cap + 4));
        n_near++;
      end else begin
        // contact distance along one axis, give or take one step
        cap = ($urandom_range(0, 9) == 0) ? 16383 : 1023;
        a = mk(pick_kind(1'b0), int'($urandom_range(0, 16383)) - 8192,
               int'($urandom_range(0, 16383)) - 8192, $urandom_range(0, cap),
               $urandom_range(0, cap), $urandom_range(0, cap));
        b = mk(pick_kind(1'b0), 0, 0, $urandom_range(0, cap),
               $urandom_range(0, cap), $urandom_range(0, cap));
        on_y = 1'($urandom_range(0, 1));
        sep  = reach(a, on_y) + reach(b, on_y) + int'($urandom_range(0, 2)) - 1;
        if ($urandom_range(0, 1) != 0) sep = -sep;
        off  = int'($urandom_range(0, 6)) - 3;
        b.x  = a.x + 16'(on_y ? off : sep);
        b.y  = a.y + 16'(on_y ? sep : off);
        n_contact++;
      end
      drive_pair(a, b);
    end

    // wait out the pipeline, then keep watching for stray results
    drain();
    repeat (8) @(posedge clk_i);

    $display("Covered %0d shape pairs: %0d directed, %0d fully random, %0d near, %0d at contact",
             n_directed + n_wide + n_near + n_contact, n_directed, n_wide, n_near, n_contact);
    $display("All kind pairings incl. the unused code, %0d hits, four receiver stall patterns",
             hit_count);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
